/* rtl/core/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer expiry queue
// Holds the beat structs of both channels, result kinds and controller states.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned NumTimers = 256;
  localparam int unsigned IdW       = $clog2(NumTimers);
  localparam int unsigned CntW      = IdW + 1;
  localparam int unsigned MaxFires  = 63;
  localparam int unsigned FireW     = 6;

  localparam logic [1:0] ActInsert  = 2'd0;
  localparam logic [1:0] ActCancel  = 2'd1;
  localparam logic [1:0] ActAdvance = 2'd2;

  localparam logic [1:0] CfgMinWait   = 2'd0;
  localparam logic [1:0] CfgMaxWait   = 2'd1;
  localparam logic [1:0] CfgLateLimit = 2'd2;

  localparam logic [2:0] KindInserted = 3'd0;
  localparam logic [2:0] KindFull     = 3'd1;
  localparam logic [2:0] KindCancelOk = 3'd2;
  localparam logic [2:0] KindBadId    = 3'd3;
  localparam logic [2:0] KindExpired  = 3'd4;
  localparam logic [2:0] KindWait     = 3'd5;

  localparam logic [1:0] StFree      = 2'd0;
  localparam logic [1:0] StLive      = 2'd1;
  localparam logic [1:0] StCancelled = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now;
    logic [31:0]        delay;
    logic [31:0]        period;
    logic signed [31:0] user_word_a;
    logic signed [31:0] user_word_b;
    logic [7:0]         timer_id;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         which_timer;
    logic signed [31:0] word_a;
    logic signed [31:0] word_b;
    logic [15:0]        wait_res;
    logic               last;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,      // read tail entry id
    S_INS_CMP0,    // tail entry id arrives, timer written
    S_BS_RD,       // read order_list[mid]
    S_BS_RDX,      // read expiry of that id
    S_BS_CMP,
    S_SH_RD,       // shift loop: read order_list[pos-1]
    S_SH_WR,       // write order_list[pos]
    S_PLACE,
    S_ADV_RD,      // read tail id
    S_ADV_RDX,     // read expiry, status, payload, period of it
    S_ADV_EVAL,
    S_ADV_FIRE,    // emit expired beat
    S_EMIT,        // single result beat
    S_EMIT_WAIT
  } state_e;

endpackage

/* rtl/core/sorted_timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue: periodic timers kept in expiry order
// Insert, cancel and advance commands over one table of timers in memories.
// ----------------------------------------------------------------------------
// An insert compares with the tail entry, then does a binary search (up to 8
// steps) and moves up each order list entry that must make room. An advance
// examines timers from the tail; each that fires is emitted and re-filed in
// expiry order, and a wait report ends it. The order list and the expiry
// memory each have one read port and one write port.
// Result beats wait in an output register; no new command is accepted while
// one waits, and an advance does not examine the next timer while one waits.
module sorted_timer_expiry_queue
  import stq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Memories: expiry, period, payloads, status, order list, free stack.
  logic [31:0]     exp_mem [NumTimers];
  logic [31:0]     per_mem [NumTimers];
  logic [31:0]     pa_mem  [NumTimers];
  logic [31:0]     pb_mem  [NumTimers];
  logic [IdW-1:0]  ord_mem [NumTimers];
  logic [IdW-1:0]  fs_mem  [NumTimers];
  logic [1:0]      st_mem  [NumTimers];
  logic [NumTimers-1:0] st_vld_q;

  state_e state_q, state_d;
  in_beat_t cmd_q, cmd_d;
  logic [9:0]  min_wait_q;
  logic [15:0] max_wait_q, late_limit_q;
  logic [CntW-1:0] ord_cnt_q, ord_cnt_d, fs_cnt_q, fs_cnt_d, used_q, used_d;
  logic [FireW-1:0] nfire_q, nfire_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [31:0]     t_q, t_d;       // expiry being filed
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic signed [32:0] dwait_q, dwait_d;
  logic            filing_adv_q, filing_adv_d;
  out_beat_t obuf_q, obuf_d;
  logic      ovld_q, ovld_d;

  // Memory port controls.
  logic            exp_we, per_we, ord_we, fs_we, st_we;
  logic [IdW-1:0]  exp_wa, ord_wa, st_wa, fs_wa, exp_ra, ord_ra, fs_ra, st_ra;
  logic [31:0]     exp_wd;
  logic [IdW-1:0]  ord_wd, fs_wd;
  logic [1:0]      st_wd;
  logic            pay_we;
  logic [31:0]     exp_rd, per_rd, pa_rd, pb_rd;
  logic [IdW-1:0]  ord_rd, fs_rd;
  logic [1:0]      st_rd_raw, st_rd;
  logic            st_rv_q;

  always_ff @(posedge clk_i) begin
    if (exp_we) exp_mem[exp_wa] <= exp_wd;
    if (per_we) per_mem[exp_wa] <= cmd_q.period;
    if (pay_we) begin
      pa_mem[exp_wa] <= cmd_q.user_word_a;
      pb_mem[exp_wa] <= cmd_q.user_word_b;
    end
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (fs_we)  fs_mem[fs_wa] <= fs_wd;
    if (st_we)  st_mem[st_wa] <= st_wd;
    exp_rd    <= exp_mem[exp_ra];
    per_rd    <= per_mem[exp_ra];
    pa_rd     <= pa_mem[exp_ra];
    pb_rd     <= pb_mem[exp_ra];
    ord_rd    <= ord_mem[ord_ra];
    fs_rd     <= fs_mem[fs_ra];
    st_rd_raw <= st_mem[st_ra];
  end

  // Status valid bits: an unwritten entry reads as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      st_rv_q  <= 1'b0;
    end else begin
      if (st_we) st_vld_q[st_wa] <= 1'b1;
      st_rv_q <= st_vld_q[st_ra];
    end
  end
  assign st_rd = st_rv_q ? st_rd_raw : StFree;

  // Signed wrap compare helpers.
  logic signed [31:0] diff_t_rd, diff_rd_now;
  assign diff_t_rd   = $signed(t_q - exp_rd);
  assign diff_rd_now = $signed(exp_rd - cmd_q.now);

  logic [CntW-1:0] mid;
  assign mid = CntW'((lo_q + hi_q) >> 1);

  // Clamp of the pending wait.
  logic [15:0] wait_clamped;
  always_comb begin
    if (dwait_q >= $signed({17'd0, max_wait_q}))      wait_clamped = max_wait_q;
    else if (dwait_q <= $signed({23'd0, min_wait_q})) wait_clamped = {6'd0, min_wait_q};
    else wait_clamped = dwait_q[15:0];
  end

  logic in_acc, out_acc;
  assign in_ready_o = (state_q == S_IDLE) && !ovld_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = ovld_q && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        case (in_data_i.action)
          ActInsert:  state_d = S_INS_RD;
          ActCancel:  state_d = S_EMIT;
          ActAdvance: state_d = S_ADV_RD;
          default:    state_d = S_IDLE;
        endcase
      end
      S_INS_RD: begin
        if (cmd_q.action == ActInsert && fs_cnt_q == '0 && used_q >= CntW'(NumTimers))
          state_d = S_EMIT;
        else state_d = S_INS_CMP0;
      end
      S_INS_CMP0: state_d = (ord_cnt_q == '0) ? S_PLACE : S_BS_RDX;
      S_BS_RDX:   state_d = S_BS_CMP;
      S_BS_CMP: begin
        if (ord_cnt_q != '0 && pos_q == ord_cnt_q && diff_t_rd < 0) state_d = S_PLACE;
        else if (pos_q == ord_cnt_q) state_d = (lo_q < hi_q) ? S_BS_RD : S_SH_RD;
        else if (lo_d < hi_d) state_d = S_BS_RD;
        else state_d = S_SH_RD;
      end
      S_BS_RD:  state_d = S_BS_RDX;
      S_SH_RD:  state_d = (pos_q == lo_q) ? S_PLACE : S_SH_WR;
      S_SH_WR:  state_d = S_SH_RD;
      S_PLACE:  state_d = filing_adv_q ? S_ADV_RD : S_EMIT_WAIT;
      S_ADV_RD: if (!ovld_q) begin
        state_d = (ord_cnt_q == '0 || nfire_q == FireW'(MaxFires)) ? S_EMIT : S_ADV_RDX;
      end
      S_ADV_RDX:  state_d = S_ADV_EVAL;
      S_ADV_EVAL: begin
        if (diff_rd_now > 0) state_d = S_EMIT;
        else if (st_rd == StLive) state_d = S_ADV_FIRE;
        else state_d = S_ADV_RD;
      end
      S_ADV_FIRE: if (!ovld_q) state_d = S_INS_CMP0;
      S_EMIT:      if (!ovld_q) state_d = S_IDLE;
      S_EMIT_WAIT: if (!ovld_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_d = cmd_q; ord_cnt_d = ord_cnt_q; fs_cnt_d = fs_cnt_q; used_d = used_q;
    nfire_d = nfire_q; id_d = id_q; t_d = t_q; lo_d = lo_q; hi_d = hi_q;
    pos_d = pos_q; dwait_d = dwait_q; filing_adv_d = filing_adv_q;
    obuf_d = obuf_q; ovld_d = ovld_q && !out_ready_i;
    exp_we = 1'b0; per_we = 1'b0; pay_we = 1'b0; ord_we = 1'b0; fs_we = 1'b0;
    st_we = 1'b0;
    exp_wa = id_q; exp_wd = t_q; ord_wa = pos_q[IdW-1:0]; ord_wd = id_q;
    st_wa = id_q; st_wd = StLive; fs_wa = fs_cnt_q[IdW-1:0]; fs_wd = id_q;
    exp_ra = id_q; st_ra = id_q;
    ord_ra = IdW'(ord_cnt_q - CntW'(1));
    fs_ra  = IdW'(fs_cnt_q - CntW'(1));
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        cmd_d = in_data_i; nfire_d = '0;
        dwait_d = $signed({17'd0, max_wait_q});
        filing_adv_d = (in_data_i.action == ActAdvance);
      end
      S_INS_RD: begin
        if (fs_cnt_q != '0) begin
          // id comes from free stack, read issued earlier (fs_ra)
          id_d = fs_rd; fs_cnt_d = fs_cnt_q - CntW'(1);
        end else if (used_q < CntW'(NumTimers)) begin
          id_d = used_q[IdW-1:0]; used_d = used_q + CntW'(1);
        end
        if (!(fs_cnt_q == '0 && used_q >= CntW'(NumTimers))) begin
          t_d = cmd_q.now + cmd_q.delay;
          obuf_d = '0; obuf_d.kind = KindInserted;
          obuf_d.which_timer = 8'(fs_cnt_q != '0 ? fs_rd : used_q[IdW-1:0]);
          obuf_d.last = 1'b1;
        end else begin
          obuf_d = '0; obuf_d.kind = KindFull; obuf_d.last = 1'b1;
        end
      end
      S_INS_CMP0: begin
        // Write the new or rearmed timer, then start search at the tail.
        exp_we = 1'b1;
        if (!filing_adv_q) begin
          per_we = 1'b1; pay_we = 1'b1; st_we = 1'b1;
        end
        pos_d = ord_cnt_q; lo_d = '0; hi_d = ord_cnt_q - CntW'(1);
        ord_ra = IdW'(ord_cnt_q - CntW'(1));
        if (ord_cnt_q == '0) pos_d = '0;
      end
      S_BS_RD: ord_ra = mid[IdW-1:0];
      S_BS_RDX: exp_ra = ord_rd;
      S_BS_CMP: begin
        if (pos_q == ord_cnt_q) begin
          // tail compare: before tail means append
          if (diff_t_rd < 0) pos_d = ord_cnt_q;
          else pos_d = '1;
        end else begin
          if (diff_t_rd < 0) lo_d = mid + CntW'(1);
          else hi_d = mid;
          pos_d = '1;
        end
        if (!(pos_q == ord_cnt_q && diff_t_rd < 0) && !(lo_d < hi_d) &&
            !(pos_q == ord_cnt_q && lo_q < hi_q))
          pos_d = ord_cnt_q;
        if (pos_q == ord_cnt_q && !(diff_t_rd < 0) && lo_q < hi_q) pos_d = '1;
      end
      S_SH_RD: begin
        if (pos_q == '1) pos_d = ord_cnt_q;
        ord_ra = IdW'(((pos_q == '1) ? ord_cnt_q : pos_q) - CntW'(1));
        if (pos_q == '1 && ord_cnt_q == lo_q) pos_d = lo_q;
      end
      S_SH_WR: begin
        ord_we = 1'b1; ord_wa = pos_q[IdW-1:0]; ord_wd = ord_rd;
        pos_d = pos_q - CntW'(1);
      end
      S_PLACE: begin
        ord_we = 1'b1; ord_wa = pos_q[IdW-1:0]; ord_wd = id_q;
        ord_cnt_d = ord_cnt_q + CntW'(1);
        if (!filing_adv_q) ovld_d = 1'b0;
      end
      S_ADV_RD: begin
        // The pending expired beat must leave before the buffer is reused.
        if (!ovld_q && (ord_cnt_q == '0 || nfire_q == FireW'(MaxFires))) begin
          obuf_d = '0; obuf_d.kind = KindWait; obuf_d.wait_res = wait_clamped;
          obuf_d.last = 1'b1;
        end
      end
      S_ADV_RDX: begin
        id_d = ord_rd; exp_ra = ord_rd; st_ra = ord_rd;
      end
      S_ADV_EVAL: begin
        dwait_d = 33'(diff_rd_now);
        if (diff_rd_now > 0) begin
          obuf_d = '0; obuf_d.kind = KindWait; obuf_d.last = 1'b1;
          if (dwait_d >= $signed({17'd0, max_wait_q})) obuf_d.wait_res = max_wait_q;
          else if (dwait_d <= $signed({23'd0, min_wait_q}))
            obuf_d.wait_res = {6'd0, min_wait_q};
          else obuf_d.wait_res = dwait_d[15:0];
        end else begin
          ord_cnt_d = ord_cnt_q - CntW'(1);
          if (st_rd == StLive) begin
            obuf_d = '0; obuf_d.kind = KindExpired; obuf_d.which_timer = 8'(id_q);
            obuf_d.word_a = pa_rd; obuf_d.word_b = pb_rd;
            if ($signed({diff_rd_now[31], diff_rd_now}) < -$signed({17'd0, late_limit_q}))
              t_d = cmd_q.now + per_rd;
            else t_d = exp_rd + per_rd;
          end else begin
            st_we = 1'b1; st_wd = StFree;
            fs_we = 1'b1; fs_wd = id_q; fs_cnt_d = fs_cnt_q + CntW'(1);
          end
        end
      end
      S_ADV_FIRE: if (!ovld_q) begin
        ovld_d = 1'b1; nfire_d = nfire_q + FireW'(1);
      end
      S_EMIT: begin
        if (cmd_q.action == ActCancel && obuf_q.last == 1'b0) begin
          obuf_d = obuf_q;
        end
        if (!ovld_q) begin
          ovld_d = 1'b1;
          if (cmd_q.action == ActCancel) begin
            obuf_d = '0; obuf_d.which_timer = cmd_q.timer_id; obuf_d.last = 1'b1;
            if (CntW'(cmd_q.timer_id) >= used_q) obuf_d.kind = KindBadId;
            else begin
              obuf_d.kind = KindCancelOk;
              st_we = 1'b1; st_wa = IdW'(cmd_q.timer_id); st_wd = StCancelled;
            end
          end
        end
      end
      S_EMIT_WAIT: if (!ovld_q) ovld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ord_cnt_q <= '0; fs_cnt_q <= '0; used_q <= '0;
      ovld_q <= 1'b0; nfire_q <= '0; filing_adv_q <= 1'b0;
      min_wait_q <= 10'd50; max_wait_q <= 16'd1000; late_limit_q <= 16'd1000;
    end else begin
      state_q <= state_d; ord_cnt_q <= ord_cnt_d; fs_cnt_q <= fs_cnt_d;
      used_q <= used_d; ovld_q <= ovld_d; nfire_q <= nfire_d;
      filing_adv_q <= filing_adv_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMinWait:   min_wait_q   <= cfg_data_i[9:0];
          CfgMaxWait:   max_wait_q   <= cfg_data_i[15:0];
          CfgLateLimit: late_limit_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; id_q <= id_d; t_q <= t_d; lo_q <= lo_d; hi_q <= hi_d;
    pos_q <= pos_d; dwait_q <= dwait_d; obuf_q <= obuf_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = obuf_q;

endmodule

/* rtl/core/stq_checker.sv */
// ----------------------------------------------------------------------------
// stq_checker: port level checks of the sorted timer expiry queue
// Watches the input and output channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module stq_checker
  import stq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  // A result beat holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // No new item while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  // Only defined result kinds appear.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KindWait)
    else $error("undefined result kind");

  // Expired beats are never the last one of an item.
  a_exp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindExpired |-> !out_data_o.last)
    else $error("expired beat flagged last");

endmodule

bind sorted_timer_expiry_queue stq_checker u_stq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
